// ===== src/fdseq_pkg.sv =====
package fdseq_pkg;

    // Operation codes of an input request
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Play modes
    localparam logic [2:0] MODE_LOOP_FWD  = 3'd0;
    localparam logic [2:0] MODE_LOOP_BWD  = 3'd1;
    localparam logic [2:0] MODE_ONCE_FWD  = 3'd2;
    localparam logic [2:0] MODE_ONCE_BWD  = 3'd3;
    localparam logic [2:0] MODE_PINGPONG  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_PLAY_MODE   = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    // Delay of every frame after reset, in ms
    localparam logic [15:0] DEFAULT_DELAY = 16'd200;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [3:0]  frame_sel;
        logic [15:0] delay_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0] frame_index;
        logic       is_playing;
        logic       going_backward;
        logic       advance_pending;
    } out_item_t;

endpackage

// ===== src/frame_delay_sequencer_core.sv =====
// Sprite frame sequencer with a per-frame delay table. Each request carries
// one operation: a tick brings the current ms time and advances the shown
// frame while its delay has run out, a write sets one delay entry, a start
// arms playback at a chosen frame. Every request gives one result. A write,
// start or unused operation passes the execute and finish states and then
// returns to idle; a tick on a playing sequence of two or more frames also
// steps through the advance state, once per advance plus one final check
// (no final check when a once mode ends at a wrap), at most MAX_ADVANCE
// advances. One shared 33-bit subtractor compares the elapsed time against the
// current delay and removes it, one advance per cycle. The input stalls while
// a request is in work; a finished result waits in an output register, so
// the next request is taken meanwhile. A result that is ready while the
// previous one still waits holds the sequencer as long as the result side
// stalls.
module frame_delay_sequencer_core #(
    parameter int MAX_FRAMES  = 16,
    parameter int MAX_ADVANCE = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  fdseq_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fdseq_pkg::out_item_t  out_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [4:0]            cfg_wdata
);

    // Largest frame count in effect (frame_count register is 5 bits)
    localparam int CNT_MAX = (MAX_FRAMES < 31) ? MAX_FRAMES : 31;
    localparam int FRW     = $clog2(CNT_MAX);
    localparam int SW      = $clog2(MAX_ADVANCE + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STEP,
        ST_FINISH
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  mode_reg;
    logic [4:0]  fcount_reg;

    logic [FRW-1:0] cur_reg, cur_next;
    logic           play_reg, play_next;
    logic           bw_reg, bw_next;
    logic [31:0]    start_reg, start_next;
    logic [15:0]    delay_reg [CNT_MAX];

    logic [1:0]     op_reg;
    logic [31:0]    now_reg;
    logic [3:0]     sel_reg;
    logic [15:0]    dly_reg;

    logic [31:0]    diff_reg, diff_next;
    logic [SW-1:0]  step_reg, step_next;
    logic           run_reg, run_next;
    logic           pend_reg, pend_next;

    logic           out_valid_reg, out_valid_next;
    fdseq_pkg::out_item_t out_reg, out_next;

    logic           tbl_we;
    logic [FRW-1:0] tbl_addr;

    logic [4:0]     cnt;
    logic [4:0]     cur5;
    logic [4:0]     sel5;
    logic [31:0]    cur_ext;
    logic [31:0]    sel_ext;
    logic [15:0]    cur_delay;
    logic [32:0]    sub;
    logic           low_cross, high_cross;
    logic [FRW-1:0] adv_cur;
    logic           adv_bw, adv_play;

    // Count in effect and widened views
    always_comb
    begin
        cnt     = (fcount_reg > 5'(CNT_MAX)) ? 5'(CNT_MAX) : fcount_reg;
        cur5    = 5'(cur_reg);
        sel5    = 5'(sel_reg);
        cur_ext = 32'(cur_reg);
        sel_ext = 32'(sel_reg);
    end

    // Shared subtractor: elapsed time minus delay of the shown frame
    always_comb
    begin
        cur_delay = delay_reg[cur_reg];
        sub       = {1'b0, diff_reg} - {17'd0, cur_delay};
    end

    // Next frame and direction for one advance
    always_comb
    begin
        low_cross  = bw_reg && (cur5 == 5'd0);
        high_cross = !bw_reg && ({1'b0, cur5} + 6'd1 >= {1'b0, cnt});
        adv_bw     = bw_reg;
        adv_play   = play_reg;
        if (mode_reg == fdseq_pkg::MODE_PINGPONG)
        begin
            if (high_cross)
            begin
                adv_cur = FRW'(cnt - 5'd2);
                adv_bw  = 1'b1;
            end
            else if (low_cross)
            begin
                adv_cur = FRW'(1);
                adv_bw  = 1'b0;
            end
            else if (bw_reg)
                adv_cur = cur_reg - FRW'(1);
            else
                adv_cur = cur_reg + FRW'(1);
        end
        else
        begin
            if (low_cross)
                adv_cur = FRW'(cnt - 5'd1);
            else if (high_cross)
                adv_cur = '0;
            else if (bw_reg)
                adv_cur = cur_reg - FRW'(1);
            else
                adv_cur = cur_reg + FRW'(1);
            if ((low_cross || high_cross) && (mode_reg inside
                {fdseq_pkg::MODE_ONCE_FWD, fdseq_pkg::MODE_ONCE_BWD}))
                adv_play = 1'b0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        play_next      = play_reg;
        bw_next        = bw_reg;
        start_next     = start_reg;
        diff_next      = diff_reg;
        step_next      = step_reg;
        run_next       = run_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        tbl_we         = 1'b0;
        tbl_addr       = sel_ext[FRW-1:0];

        // Drop a result once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                pend_next  = 1'b0;
                run_next   = 1'b0;
                state_next = ST_FINISH;
                case (op_reg)
                    fdseq_pkg::OP_TICK:
                    begin
                        if (cnt < 5'd2 || !play_reg)
                            start_next = now_reg;
                        else
                        begin
                            if (cur5 >= cnt)
                                cur_next = FRW'(cnt - 5'd1);
                            diff_next  = now_reg - start_reg;
                            step_next  = '0;
                            run_next   = 1'b1;
                            state_next = ST_STEP;
                        end
                    end
                    fdseq_pkg::OP_WRITE:
                    begin
                        if (sel5 < cnt)
                            tbl_we = 1'b1;
                    end
                    fdseq_pkg::OP_START:
                    begin
                        if (cnt == 5'd0)
                            cur_next = '0;
                        else if (sel5 < cnt)
                            cur_next = sel_ext[FRW-1:0];
                        else
                            cur_next = FRW'(cnt - 5'd1);
                        play_next  = 1'b1;
                        start_next = now_reg;
                        bw_next    = (mode_reg == fdseq_pkg::MODE_LOOP_BWD) ||
                                     (mode_reg == fdseq_pkg::MODE_ONCE_BWD);
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_STEP:
            begin
                if (sub[32])
                    state_next = ST_FINISH;
                else if (step_reg == SW'(MAX_ADVANCE))
                begin
                    pend_next  = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    // Advance one frame and consume its delay
                    cur_next  = adv_cur;
                    bw_next   = adv_bw;
                    play_next = adv_play;
                    diff_next = sub[31:0];
                    step_next = step_reg + SW'(1);
                    if (!adv_play)
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    // Timer is now minus the time still left over
                    if (run_reg)
                        start_next = now_reg - diff_reg;
                    out_valid_next          = 1'b1;
                    out_next.frame_index    = cur_ext[3:0];
                    out_next.is_playing     = play_reg;
                    out_next.going_backward = bw_reg;
                    out_next.advance_pending = pend_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= fdseq_pkg::MODE_LOOP_FWD;
            fcount_reg    <= 5'd1;
            cur_reg       <= '0;
            play_reg      <= 1'b0;
            bw_reg        <= 1'b0;
            start_reg     <= '0;
            step_reg      <= '0;
            run_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            play_reg      <= play_next;
            bw_reg        <= bw_next;
            start_reg     <= start_next;
            step_reg      <= step_next;
            run_reg       <= run_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                if (cfg_index == fdseq_pkg::CFG_PLAY_MODE)
                    mode_reg <= cfg_wdata[2:0];
                else
                    fcount_reg <= cfg_wdata;
            end
        end
    end

    // Delay table, every entry back to the default on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CNT_MAX; i++)
                delay_reg[i] <= fdseq_pkg::DEFAULT_DELAY;
        end
        else if (tbl_we)
            delay_reg[tbl_addr] <= dly_reg;
    end

    // Capture the request and hold the payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg  <= in_data.operation;
            now_reg <= in_data.now_ms;
            sel_reg <= in_data.frame_sel;
            dly_reg <= in_data.delay_ms;
        end
        diff_reg <= diff_next;
        out_reg  <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // An accepted request puts the sequencer to work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_EXEC)
        else $error("accepted request did not start execution");

    // Advance count stays within the per-tick bound
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> step_reg <= SW'(MAX_ADVANCE))
        else $error("advance count beyond bound");

    // Shown frame stays inside the count while advancing
    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> cur5 < cnt)
        else $error("frame outside count during advance");

    // A pending advance is only reported while playback runs
    a_pending_play: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.advance_pending |-> out_data.is_playing)
        else $error("pending advance reported with playback stopped");

endmodule
